FILE: rtl/integer_batch_sorter_core_macros.svh
// ----------------------------------------------------------------------------
// integer_batch_sorter_core_macros.svh
// assertion macros used by the sorter sequencer (ibs_ctrl), empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef INTEGER_BATCH_SORTER_CORE_MACROS_SVH
`define INTEGER_BATCH_SORTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibs assertion failed");

// next-cycle implication
`define IBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibs assertion failed");

`else

`define IBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/ibs_pkg.sv
// ----------------------------------------------------------------------------
// ibs_pkg
// types and constants of the integer batch sorter
// ----------------------------------------------------------------------------
package ibs_pkg;

    // width of one sorted integer
    localparam int IBS_VALUE_W = 32;

    // input beat
    typedef struct packed {
        logic signed [IBS_VALUE_W-1:0] item_value;
        logic                          is_last;
    } ibs_item_t;

    // output beat
    typedef struct packed {
        logic signed [IBS_VALUE_W-1:0] sorted_value;
        logic                          end_of_run;
        logic                          dropped;
    } ibs_result_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the new value into the chain
        logic shift;    // move every value one cell toward the head
    } ibs_cell_ctrl_t;

    // controller phases
    typedef enum logic {
        IBS_FILL,
        IBS_DRAIN
    } ibs_state_t;

endpackage

FILE: rtl/ibs_cell.sv
// ----------------------------------------------------------------------------
// ibs_cell
// one cell of the insertion chain: holds one value and its valid bit
// ----------------------------------------------------------------------------
module ibs_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ibs_pkg::ibs_cell_ctrl_t                ctrl,
    input  logic signed [ibs_pkg::IBS_VALUE_W-1:0] new_value,
    input  logic                                   prev_lt,
    input  logic signed [ibs_pkg::IBS_VALUE_W-1:0] prev_value,
    input  logic                                   prev_valid,
    input  logic signed [ibs_pkg::IBS_VALUE_W-1:0] next_value,
    input  logic                                   next_valid,
    output logic signed [ibs_pkg::IBS_VALUE_W-1:0] value,
    output logic                                   valid,
    output logic                                   lt
);

    logic signed [ibs_pkg::IBS_VALUE_W-1:0] value_reg;
    logic signed [ibs_pkg::IBS_VALUE_W-1:0] value_next;
    logic                                   valid_reg;
    logic                                   valid_next;

    // new value belongs ahead of this cell (empty cells count as +inf)
    assign lt = !valid_reg || (new_value < value_reg);

    // pick held, left neighbor, new or right neighbor value
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.insert && lt)
        begin
            if (prev_lt)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

FILE: rtl/ibs_ctrl.sv
// ----------------------------------------------------------------------------
// ibs_ctrl
// fill / drain sequencer: counts held values, tracks overflow, drives chain
// ----------------------------------------------------------------------------
`include "integer_batch_sorter_core_macros.svh"

module ibs_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    item_last,
    output logic                    item_stall,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic                    end_of_run,
    output logic                    dropped,
    output ibs_pkg::ibs_cell_ctrl_t cell_ctrl
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ibs_pkg::ibs_state_t state_reg;
    ibs_pkg::ibs_state_t state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                overflow_reg;
    logic                overflow_next;

    logic                full;
    logic                item_take;
    logic                result_take;

    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign item_take   = item_valid && !item_stall;
    assign result_take = result_valid && !result_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ibs_pkg::IBS_FILL:
            begin
                if (item_take && item_last)
                begin
                    state_next = ibs_pkg::IBS_DRAIN;
                end
            end
            ibs_pkg::IBS_DRAIN:
            begin
                if (result_take && end_of_run)
                begin
                    state_next = ibs_pkg::IBS_FILL;
                end
            end
            default:
            begin
                state_next = ibs_pkg::IBS_FILL;
            end
        endcase
    end

    // outputs per state
    always_comb
    begin
        item_stall   = 1'b1;
        result_valid = 1'b0;
        case (state_reg)
            ibs_pkg::IBS_FILL:
            begin
                item_stall = 1'b0;
            end
            ibs_pkg::IBS_DRAIN:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // chain control
    assign cell_ctrl.insert = item_take && !full;
    assign cell_ctrl.shift  = result_take;

    // result flags
    assign end_of_run = (count_reg == CNT_W'(1));
    assign dropped    = overflow_reg;

    // count and overflow update
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (item_take)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (result_take)
        begin
            count_next = count_reg - CNT_W'(1);
            if (end_of_run)
            begin
                overflow_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ibs_pkg::IBS_FILL;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // checks
    `IBS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `IBS_ASSERT_IMPL(a_drain_nonempty, clk, rst_n, state_reg == ibs_pkg::IBS_DRAIN,
                     count_reg != '0)
    `IBS_ASSERT_NEXT(a_batch_cleared, clk, rst_n, result_take && end_of_run,
                     count_reg == '0 && !overflow_reg && state_reg == ibs_pkg::IBS_FILL)
    `IBS_ASSERT_NEXT(a_overflow_set, clk, rst_n, item_take && full, overflow_reg)

endmodule

FILE: rtl/integer_batch_sorter_core.sv
// ----------------------------------------------------------------------------
// integer_batch_sorter_core
// ascending sort of a batch of signed 32-bit integers in a chain of cells
// ----------------------------------------------------------------------------
// usage:
//   item channel: one signed integer per beat, is_last marks the batch end.
//   while filling, one item beat is taken every cycle; each value is placed
//   into its sorted slot of the cell chain in the same cycle.
//   items beyond CAPACITY are discarded and flag dropped on the whole batch.
//   after the marked beat the block drains: item_stall is high and the chain
//   shifts toward its head, one result beat per cycle while result_stall is
//   low, smallest first, with end_of_run on the largest. a batch of n held
//   values takes n result beats. the first result is valid the cycle after
//   the marked item is taken. the rates above are set by the single compare
//   and shift per cell in each cycle.
//   result_stall holds the chain; the shown beat stays until taken.
//   reset empties the chain and returns to filling; no clearing pass.
// ----------------------------------------------------------------------------
module integer_batch_sorter_core #(
    parameter int CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  ibs_pkg::ibs_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ibs_pkg::ibs_result_t result
);

    ibs_pkg::ibs_cell_ctrl_t                cell_ctrl;
    logic                                   end_of_run;
    logic                                   dropped;

    logic signed [ibs_pkg::IBS_VALUE_W-1:0] cell_value [CAPACITY];
    logic                                   cell_valid [CAPACITY];
    logic                                   cell_lt    [CAPACITY];

    // sequencer
    ibs_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_last    (item.is_last),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .end_of_run   (end_of_run),
        .dropped      (dropped),
        .cell_ctrl    (cell_ctrl)
    );

    // cell chain, cell 0 holds the smallest value
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                                   prev_lt;
        logic signed [ibs_pkg::IBS_VALUE_W-1:0] prev_value;
        logic                                   prev_valid;
        logic signed [ibs_pkg::IBS_VALUE_W-1:0] next_value;
        logic                                   next_valid;

        if (i == 0)
        begin : g_head
            assign prev_lt    = 1'b0;
            assign prev_value = '0;
            assign prev_valid = 1'b0;
        end
        else
        begin : g_body
            assign prev_lt    = cell_lt[i-1];
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_value = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_link
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        ibs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .new_value  (item.item_value),
            .prev_lt    (prev_lt),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .lt         (cell_lt[i])
        );
    end

    // result beat straight from the head cell register
    assign result.sorted_value = cell_value[0];
    assign result.end_of_run   = end_of_run;
    assign result.dropped      = dropped;

endmodule
